@@ sv/dtfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_pkg: shared types and constants for the double to fixed converter
// Field widths, operation codes of the front/back queue and register indexes.
// ----------------------------------------------------------------------------
package dtfc_pkg;

  localparam int WORD_BITS    = 64;
  localparam int MAN_BITS     = 52;
  localparam int EXP_BITS     = 11;
  localparam int EXP_BIAS     = 1023;
  localparam int RSHIFT_LIMIT = 55;
  localparam int TB_BITS      = 7;
  localparam int FB_BITS      = 12;
  localparam int SH_BITS      = 14;   // signed shift amount, holds -3122..3019
  localparam int AMT_BITS     = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = 1;
  localparam int QCNT_BITS    = 2;
  localparam int ADDR_BITS    = 3;

  // register indexes (paddr[2])
  localparam logic REG_TOTAL_BITS = 1'b0;
  localparam logic REG_FRAC_BITS  = 1'b1;

  // work codes handed from front to back
  localparam logic [1:0] OP_ZERO  = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;
  localparam logic [1:0] OP_RIGHT = 2'd2;
  localparam logic [1:0] OP_NAN   = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic                neg;
    logic [AMT_BITS-1:0] amt;   // left: shift; right: shift minus one
    logic [MAN_BITS:0]   man;   // significand with hidden bit
  } q_entry_t;

endpackage

@@ sv/dtfc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_front: input stage
// Takes a raw binary64 pattern, works out the shift and classifies the work.
// ----------------------------------------------------------------------------
module dtfc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dtfc_pkg::WORD_BITS-1:0] value_bits,
  input  logic [dtfc_pkg::FB_BITS-1:0]   frac_len,
  output logic                           push,
  output dtfc_pkg::q_entry_t             push_entry,
  input  logic                           queue_full
);
  import dtfc_pkg::*;

  logic                  front_valid;
  q_entry_t              entry;
  q_entry_t              entry_next;
  logic                  take;
  logic [EXP_BITS-1:0]   expf;
  logic [EXP_BITS-1:0]   exp_eff;
  logic signed [SH_BITS-1:0] sh;

  // held busy through reset so no transfer is taken and dropped
  assign busy = rst || (front_valid && queue_full);
  assign take = start && !busy;
  assign push = front_valid && !queue_full;
  assign push_entry = entry;

  always_comb begin
    expf    = value_bits[WORD_BITS-2 -: EXP_BITS];
    // subnormals use an exponent of one
    exp_eff = (expf != '0) ? expf : EXP_BITS'(1);
    sh = $signed({{(SH_BITS-EXP_BITS){1'b0}}, exp_eff})
       + $signed({{(SH_BITS-FB_BITS){frac_len[FB_BITS-1]}}, frac_len})
       - SH_BITS'(MAN_BITS + EXP_BIAS);
    entry_next.neg = value_bits[WORD_BITS-1];
    entry_next.man = {(expf != '0), value_bits[MAN_BITS-1:0]};
    entry_next.amt = sh[AMT_BITS-1:0];
    if (expf == '1) begin
      entry_next.op = OP_NAN;
    end else if (sh >= 0) begin
      entry_next.op = (sh < SH_BITS'(WORD_BITS)) ? OP_LEFT : OP_ZERO;
    end else begin
      // right by r = -sh; store r - 1 = ~sh
      entry_next.amt = ~sh[AMT_BITS-1:0];
      entry_next.op  = (sh > -SH_BITS'(RSHIFT_LIMIT)) ? OP_RIGHT : OP_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry <= entry_next;
    end
  end

endmodule

@@ sv/dtfc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_queue: short queue between front and back
// Two-entry FIFO with show-ahead output.
// ----------------------------------------------------------------------------
module dtfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dtfc_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output dtfc_pkg::q_entry_t pop_entry
);
  import dtfc_pkg::*;

  q_entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ sv/dtfc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_back: execution stages
// Stage 1 shifts and rounds the magnitude; stage 2 negates and wraps.
// ----------------------------------------------------------------------------
module dtfc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  dtfc_pkg::q_entry_t             in_entry,
  output logic                           pop,
  input  logic [dtfc_pkg::TB_BITS-1:0]   total_bits,
  output logic                           done,
  output logic [dtfc_pkg::WORD_BITS-1:0] fixed_value,
  output logic                           not_finite
);
  import dtfc_pkg::*;

  // stage 1
  logic                  s1_valid;
  logic                  s1_neg;
  logic                  s1_nan;
  logic [WORD_BITS-1:0]  s1_mag;
  logic [WORD_BITS-1:0]  mag_next;
  logic [MAN_BITS+1:0]   rsh;
  logic [MAN_BITS+1:0]   rsum;

  // stage 2
  logic [WORD_BITS-1:0]  signed_val;
  logic [WORD_BITS-1:0]  wrap_mask;
  logic [AMT_BITS-1:0]   sign_idx;
  logic                  no_wrap;
  logic [WORD_BITS-1:0]  wrapped;

  // the back end never stalls: it drains one entry per cycle
  assign pop = in_valid;

  always_comb begin
    rsh  = {1'b0, in_entry.man} >> in_entry.amt;
    rsum = rsh + 1'b1;   // half an LSB, then drop it
    case (in_entry.op)
      OP_LEFT:  mag_next = {{(WORD_BITS-MAN_BITS-1){1'b0}}, in_entry.man} << in_entry.amt;
      OP_RIGHT: mag_next = {{(WORD_BITS-MAN_BITS-1){1'b0}}, rsum[MAN_BITS+1:1]};
      default:  mag_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_neg <= in_entry.neg;
      s1_nan <= (in_entry.op == OP_NAN);
      s1_mag <= mag_next;
    end
  end

  always_comb begin
    signed_val = s1_neg ? (~s1_mag + 1'b1) : s1_mag;
    no_wrap    = (total_bits >= TB_BITS'(WORD_BITS));
    // width zero behaves as width one
    sign_idx   = (total_bits == '0) ? '0 : AMT_BITS'(total_bits - 1'b1);
    wrap_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1};
    wrap_mask  = (wrap_mask << sign_idx);
    wrap_mask  = wrap_mask | (wrap_mask - 1'b1);
    if (no_wrap) begin
      wrapped = signed_val;
    end else if (signed_val[sign_idx]) begin
      wrapped = signed_val | ~wrap_mask;
    end else begin
      wrapped = signed_val & wrap_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fixed_value <= s1_nan ? '0 : wrapped;
      not_finite  <= s1_nan;
    end
  end

endmodule

@@ sv/double_to_fixed_convert_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_fixed_convert_unit: binary64 to fixed-point converter
// Converts raw binary64 patterns to two's-complement fixed point, with
// round half away from zero, wrap to total_bits and a not-finite flag.
// ----------------------------------------------------------------------------
// Usage: one value can be started every clock cycle. A value transferred at a
// rising edge (start high, busy low) comes out with done high for one cycle,
// after it has passed the front classify register, the queue, the
// shift/round stage and the negate/wrap output register. The back end
// drains one queue entry per cycle, so busy stays low in operation; it is high
// during reset. Results are not held: the receiver must take each one in the
// cycle done is high. Write total_bits and frac_len only while no
// conversion is in flight.
module double_to_fixed_convert_unit (
  input  logic                             clk,
  input  logic                             rst,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [dtfc_pkg::WORD_BITS-1:0]   value_bits,
  // result side
  output logic                             done,
  output logic [dtfc_pkg::WORD_BITS-1:0]   fixed_value,
  output logic                             not_finite,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dtfc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dtfc_pkg::*;

  logic [TB_BITS-1:0] total_bits;
  logic [FB_BITS-1:0] frac_len;
  logic               reg_wr;
  logic               push;
  q_entry_t           push_entry;
  logic               queue_full;
  logic               pop;
  logic               q_not_empty;
  q_entry_t           pop_entry;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= TB_BITS'(WORD_BITS);
      frac_len   <= '0;
    end else if (reg_wr) begin
      unique case (paddr[2])
        REG_TOTAL_BITS: total_bits <= pwdata[TB_BITS-1:0];
        REG_FRAC_BITS:  frac_len   <= pwdata[FB_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_BITS: prdata = {{(32-TB_BITS){1'b0}}, total_bits};
      REG_FRAC_BITS:  prdata = {{(32-FB_BITS){1'b0}}, frac_len};
      default:        prdata = '0;
    endcase
  end

  dtfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .frac_len   (frac_len),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  dtfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  dtfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_not_empty),
    .in_entry    (pop_entry),
    .pop         (pop),
    .total_bits  (total_bits),
    .done        (done),
    .fixed_value (fixed_value),
    .not_finite  (not_finite)
  );

endmodule

@@ sv/dtfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_checker: port-level checks for the converter
// Latency, result pairing, the not-finite result rule and no input stall.
// ----------------------------------------------------------------------------
module dtfc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [dtfc_pkg::WORD_BITS-1:0] fixed_value,
  input logic                           not_finite
);

  // every transfer yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result missing four cycles after transfer");

  // no result without a matching transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a transfer");

  // NaN and infinity give a zero value
  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    (done && not_finite) |-> (fixed_value == '0))
    else $error("not-finite result with nonzero value");

  // the back end drains every cycle, so the front never backs up
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !busy)
    else $error("converter stalled its input");

endmodule

bind double_to_fixed_convert_unit dtfc_checker u_dtfc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .fixed_value (fixed_value),
  .not_finite  (not_finite)
);

@@ sim/double_to_fixed_convert_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_fixed_convert_unit_tb: self-checking bench for the binary64 to
// fixed-point converter
// Streams raw binary64 patterns through the command port in random bursts,
// predicts each conversion from the current total_bits/frac_len setting and
// compares every result strobe, field by field, with the oldest prediction.
// Formats are changed over the APB port between phases, extremes included.
// ----------------------------------------------------------------------------
module double_to_fixed_convert_unit_tb;
  import dtfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [WORD_BITS-1:0] src;
    logic [WORD_BITS-1:0] value;
    logic                 not_finite;
  } fixed_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [WORD_BITS-1:0] value_bits;
  logic                 done;
  logic [WORD_BITS-1:0] fixed_value;
  logic                 not_finite;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  fixed_result_t        expected_results[$];
  logic [TB_BITS-1:0]   cur_total;
  logic [FB_BITS-1:0]   cur_frac;
  int                   error_count;
  int                   cycle_count;
  int                   burst_left;

  double_to_fixed_convert_unit uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .done       (done),
    .fixed_value(fixed_value),
    .not_finite (not_finite),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_to_fixed_convert_unit: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Fixed-point conversion with round half away from zero and wrap.
  function automatic fixed_result_t convert_double(input logic [WORD_BITS-1:0] bits,
                                                   input logic [TB_BITS-1:0] tbits,
                                                   input logic signed [FB_BITS-1:0] fbits);
    fixed_result_t        res;
    logic [EXP_BITS-1:0]  expf;
    logic [WORD_BITS-1:0] mag;
    logic [WORD_BITS-1:0] mask;
    int                   exp_val;
    int                   shift;
    int                   width;
    res.src        = bits;
    res.value      = '0;
    res.not_finite = 1'b0;
    expf = bits[62:52];
    mag  = {12'd0, bits[MAN_BITS-1:0]};
    if (expf == '1) begin
      res.not_finite = 1'b1;
      return res;
    end
    if (expf != '0) begin
      mag[MAN_BITS] = 1'b1;
      exp_val = int'(expf);
    end else begin
      exp_val = 1;   // subnormal
    end
    shift = exp_val + int'(fbits) - MAN_BITS - EXP_BIAS;
    if (shift >= 0) begin
      mag = (shift < WORD_BITS) ? (mag << shift) : '0;
    end else if (-shift < RSHIFT_LIMIT) begin
      mag = (mag + (64'd1 << (-shift - 1))) >> (-shift);
    end else begin
      mag = '0;
    end
    if (bits[63]) mag = -mag;
    width = int'(tbits);
    if (width > WORD_BITS) width = WORD_BITS;
    if (width == 0) width = 1;
    if (width < WORD_BITS) begin
      mask = (64'd1 << width) - 64'd1;
      mag  = mag & mask;
      if (mag[width-1]) mag = mag | ~mask;
    end
    res.value = mag;
    return res;
  endfunction

  // Exponent aimed at the interesting shift window for the current format.
  function automatic logic [WORD_BITS-1:0] random_double(input logic signed [FB_BITS-1:0] fbits);
    logic [WORD_BITS-1:0] v;
    int                   kind;
    int                   e;
    int                   k;
    v    = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      e = EXP_BIAS + MAN_BITS - int'(fbits) + int'($urandom_range(0, 135)) - 65;
      if (e < 0) e = 0;
      if (e > 2046) e = 2046;
      v[62:52] = e[EXP_BITS-1:0];
      if (kind < 25) begin
        // clear low mantissa bits so exact halves show up
        k = $urandom_range(1, MAN_BITS);
        v = v & ~((64'd1 << k) - 64'd1);
      end
    end else if (kind < 80) begin
      v[62:52] = '0;
    end else if (kind < 85) begin
      v[62:52] = '1;
    end
    return v;
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic send_value(input logic [WORD_BITS-1:0] v);
    start      <= 1'b1;
    value_bits <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(convert_double(v, cur_total, cur_frac));
    pace_sender();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TOTAL_BITS) cur_total = data[TB_BITS-1:0];
    else cur_frac = data[FB_BITS-1:0];
  endtask

  task automatic set_format(input logic [TB_BITS-1:0] tbits, input logic [FB_BITS-1:0] fbits);
    wait_idle();
    write_reg(REG_TOTAL_BITS, {25'd0, tbits});
    write_reg(REG_FRAC_BITS, {20'd0, fbits});
  endtask

  // Reset format: signed zero, rounding ties, shift limits, subnormals,
  // infinities and NaNs.
  task automatic test_reset_format();
    logic [WORD_BITS-1:0] vals[$];
    vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
             64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
             64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
             64'h3FF8_0000_0000_0000, 64'h4004_0000_0000_0000,
             64'hC004_0000_0000_0000, 64'h3FDF_FFFF_FFFF_FFFF,
             64'h3FD0_0000_0000_0000, 64'h3FC0_0000_0000_0000,
             64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
             64'h4720_0000_0000_0000, 64'h4730_0000_0000_0000,
             64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
             64'h800F_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
             64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000,
             64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Format extremes: narrowest, zero and oversized widths, frac range limits.
  task automatic test_format_extremes();
    logic [TB_BITS-1:0] tlist[$];
    logic [FB_BITS-1:0] flist[$];
    tlist = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd64, 7'd16, 7'd16, 7'd65, 7'd32, 7'd63};
    flist = '{12'd0, 12'd3, 12'd10, 12'd1024, -12'sd1024, 12'd2047, 12'h800,
              -12'sd3, 12'd16, 12'd52};
    foreach (tlist[i]) begin
      set_format(tlist[i], flist[i]);
      send_value(64'h3FF0_0000_0000_0000);
      send_value(64'hBFE0_0000_0000_0000);
      send_value(64'h0000_0000_0000_0001);
      send_value(64'hFFF8_0000_0000_0000);
      repeat (12) send_value(random_double(cur_frac));
    end
  endtask

  task automatic test_random_streams();
    logic [FB_BITS-1:0] fbits;
    for (int phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 1) == 0) fbits = 12'($urandom);
      else fbits = 12'($signed($urandom_range(0, 140)) - 60);
      set_format(7'($urandom_range(0, 127)), fbits);
      repeat (75) send_value(random_double(cur_frac));
    end
  endtask

  always @(posedge clk) begin
    fixed_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", fixed_value));
      end else begin
        want = expected_results.pop_front();
        if (fixed_value !== want.value)
          report_mismatch($sformatf("in %h: fixed_value %h, want %h",
                                    want.src, fixed_value, want.value));
        if (not_finite !== want.not_finite)
          report_mismatch($sformatf("in %h: not_finite %b, want %b",
                                    want.src, not_finite, want.not_finite));
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_left  = 1;
    cur_total   = 7'd64;
    cur_frac    = '0;
    rst        <= 1'b1;
    start      <= 1'b0;
    value_bits <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_format();
    test_format_extremes();
    test_random_streams();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("conversion never completed");
    end
    if (error_count == 0) begin
      $display("double_to_fixed_convert_unit: match");
    end else begin
      $display("double_to_fixed_convert_unit: mismatch");
    end
    $finish;
  end

endmodule
